FILE: rtl/core/bmfr_pkg.sv
// bmfr_pkg: shared types and constants for the binary message frame receiver
// depends on nothing; imported by binary_message_frame_receiver_top
`default_nettype none

package bmfr_pkg;

    // fixed field widths of the result transaction
    localparam int KIND_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int SEQ_W   = 64;
    localparam int TLEN_OW = 9;
    localparam int PLEN_OW = 11;

    // header layout
    localparam int HDR_BYTES = 16;
    localparam int HDR_W     = HDR_BYTES * BYTE_W;
    localparam int HPOS_W    = 4;
    localparam logic [BYTE_W-1:0] VERSION_ONE = 8'h01;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_TOPIC     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY_END = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BAD_VER   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TOO_LARGE = 3'd4;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_EXACTLY_ONCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PUBLISH_CODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_PUBLISH = 2'd2;

    localparam logic [BYTE_W-1:0] PUBLISH_CODE_RST = 8'd1;
    localparam logic [BYTE_W-1:0] SIGNED_CODE_RST  = 8'd16;

    typedef struct packed {
        logic [KIND_W-1:0]  event_kind;
        logic [BYTE_W-1:0]  data_byte;
        logic               end_of_message;
        logic               signed_message;
        logic               ack_request;
        logic [SEQ_W-1:0]   sequence_res;
        logic [TLEN_OW-1:0] topic_length;
        logic [PLEN_OW-1:0] delivered_payload_length;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/binary_message_frame_receiver_top.sv
// binary_message_frame_receiver_top: frame parser with two-entry output skid
// depends on bmfr_pkg
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid, in_ready, rx_byte               | in
//  result   | out_valid, out_ready, event_kind ..       | out
//  config   | cfg_write, cfg_index, cfg_data            | in
//
// one received byte per cycle while in_ready is high; any result is registered
// the frame state is updated in the cycle the byte is accepted
// a result and a skid entry can wait; in_ready drops only when the skid is full
// reset clears the parser state and config; the header shift line needs no clearing
`default_nettype none

module binary_message_frame_receiver_top
    import bmfr_pkg::*;
#(
    parameter int MAX_TOPIC_BYTES        = 256,
    parameter int MAX_PAYLOAD_BYTES      = 2000,
    parameter int SIGNATURE_PREFIX_BYTES = 68
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output      logic                  in_ready,
    input  wire logic [BYTE_W-1:0]     rx_byte,

    output      logic                  out_valid,
    input  wire logic                  out_ready,
    output      logic [KIND_W-1:0]     event_kind,
    output      logic [BYTE_W-1:0]     data_byte,
    output      logic                  end_of_message,
    output      logic                  signed_message,
    output      logic                  ack_request,
    output      logic [SEQ_W-1:0]      sequence_res,
    output      logic [TLEN_OW-1:0]    topic_length,
    output      logic [PLEN_OW-1:0]    delivered_payload_length,

    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int TLEN_W = $clog2(MAX_TOPIC_BYTES + 1);
    localparam int PLEN_W = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam int POS_W  = $clog2(MAX_TOPIC_BYTES + MAX_PAYLOAD_BYTES + 1);

    localparam logic PH_HEADER = 1'b0;
    localparam logic PH_BODY   = 1'b1;

    // configuration
    logic              exactly_once_reg;
    logic [BYTE_W-1:0] publish_code_reg;
    logic [BYTE_W-1:0] signed_code_reg;

    // parser state
    logic              phase_reg, phase_next;
    logic [HPOS_W-1:0] hpos_reg, hpos_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [HDR_W-BYTE_W-1:0] hdr_reg;
    logic [BYTE_W-1:0] cmd_reg, cmd_next;
    logic [TLEN_W-1:0] tlen_reg, tlen_next;
    logic [PLEN_W-1:0] plen_reg, plen_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;

    // output skid
    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;

    logic    accept, pop, push;
    result_t res;

    // header decode
    logic [HDR_W-1:0]  hdr_full;
    logic [BYTE_W-1:0] h_ver, h_cmd;
    logic [15:0]       h_tlen;
    logic [31:0]       h_plen;
    logic [SEQ_W-1:0]  h_seq;

    // fields of the frame the result refers to
    logic [BYTE_W-1:0] f_cmd;
    logic [TLEN_W-1:0] f_tlen;
    logic [PLEN_W-1:0] f_plen;
    logic [SEQ_W-1:0]  f_seq;
    logic              f_publish, f_signed, f_skip;
    logic [31:0]       f_dlen;

    logic              last;
    logic [31:0]       pay_off;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;
    assign pop      = out_valid_reg && out_ready;

    assign hdr_full = {hdr_reg, rx_byte};
    assign h_ver    = hdr_full[HDR_W-1 -: BYTE_W];
    assign h_cmd    = hdr_full[HDR_W-BYTE_W-1 -: BYTE_W];
    assign h_tlen   = hdr_full[HDR_W-2*BYTE_W-1 -: 16];
    assign h_plen   = hdr_full[HDR_W-4*BYTE_W-1 -: 32];
    assign h_seq    = hdr_full[SEQ_W-1:0];

    always_comb
    begin
        // frame fields: freshly decoded on the final header byte, else the stored ones
        if (phase_reg == PH_HEADER)
        begin
            f_cmd  = h_cmd;
            f_tlen = TLEN_W'(h_tlen);
            f_plen = PLEN_W'(h_plen);
            f_seq  = h_seq;
        end
        else
        begin
            f_cmd  = cmd_reg;
            f_tlen = tlen_reg;
            f_plen = plen_reg;
            f_seq  = seq_reg;
        end
        f_signed  = (f_cmd == signed_code_reg);
        f_publish = (f_cmd == publish_code_reg) || f_signed;
        f_skip    = f_signed && (32'(f_plen) >= 32'(SIGNATURE_PREFIX_BYTES));
        f_dlen    = 32'(f_plen) - (f_skip ? 32'(SIGNATURE_PREFIX_BYTES) : 32'd0);
    end

    always_comb
    begin
        phase_next = phase_reg;
        hpos_next  = hpos_reg;
        pos_next   = pos_reg;
        cmd_next   = cmd_reg;
        tlen_next  = tlen_reg;
        plen_next  = plen_reg;
        seq_next   = seq_reg;
        push       = 1'b0;
        last       = 1'b0;
        pay_off    = 32'(pos_reg) - 32'(tlen_reg);

        res.event_kind               = KIND_TOPIC;
        res.data_byte                = rx_byte;
        res.end_of_message           = 1'b0;
        res.signed_message           = f_signed;
        res.ack_request              = 1'b0;
        res.sequence_res             = f_seq;
        res.topic_length             = TLEN_OW'(32'(f_tlen));
        res.delivered_payload_length = f_dlen[PLEN_OW-1:0];

        if (phase_reg == PH_HEADER)
        begin
            hpos_next = hpos_reg + 1'b1;
            if (hpos_reg == HPOS_W'(HDR_BYTES - 1))
            begin
                if (h_ver != VERSION_ONE)
                begin
                    push = 1'b1;
                    res  = '0;
                    res.event_kind = KIND_BAD_VER;
                end
                else if (32'(h_tlen) > 32'(MAX_TOPIC_BYTES)
                         || h_plen > 32'(MAX_PAYLOAD_BYTES))
                begin
                    push = 1'b1;
                    res  = '0;
                    res.event_kind = KIND_TOO_LARGE;
                end
                else
                begin
                    cmd_next  = f_cmd;
                    tlen_next = f_tlen;
                    plen_next = f_plen;
                    seq_next  = f_seq;
                    pos_next  = '0;
                    if (h_tlen == '0 && h_plen == '0)
                    begin
                        // publish with no body ends right here
                        push                = f_publish;
                        res.event_kind      = KIND_EMPTY_END;
                        res.data_byte       = '0;
                        res.end_of_message  = 1'b1;
                        res.ack_request     = exactly_once_reg && (f_seq != '0);
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                    end
                end
            end
        end
        else
        begin
            last = (32'(pos_reg) + 32'd1) >= (32'(tlen_reg) + 32'(plen_reg));
            if (last)
            begin
                phase_next = PH_HEADER;
                pos_next   = '0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
            res.end_of_message = last;
            res.ack_request    = last && exactly_once_reg && (seq_reg != '0);
            if (f_publish)
            begin
                if (32'(pos_reg) < 32'(tlen_reg))
                begin
                    push           = 1'b1;
                    res.event_kind = KIND_TOPIC;
                end
                else if (pay_off >= (f_skip ? 32'(SIGNATURE_PREFIX_BYTES) : 32'd0))
                begin
                    push           = 1'b1;
                    res.event_kind = KIND_PAYLOAD;
                end
                else if (last)
                begin
                    // last byte falls inside the skipped signature
                    push           = 1'b1;
                    res.event_kind = KIND_EMPTY_END;
                    res.data_byte  = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exactly_once_reg <= 1'b0;
            publish_code_reg <= PUBLISH_CODE_RST;
            signed_code_reg  <= SIGNED_CODE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_EXACTLY_ONCE:   exactly_once_reg <= cfg_data[0];
                CFG_PUBLISH_CODE:   publish_code_reg <= cfg_data;
                CFG_SIGNED_PUBLISH: signed_code_reg  <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            hpos_reg  <= '0;
            pos_reg   <= '0;
            cmd_reg   <= '0;
            tlen_reg  <= '0;
            plen_reg  <= '0;
            seq_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            hpos_reg  <= hpos_next;
            pos_reg   <= pos_next;
            cmd_reg   <= cmd_next;
            tlen_reg  <= tlen_next;
            plen_reg  <= plen_next;
            seq_reg   <= seq_next;
        end
    end

    // header shift line, oldest byte at the top
    always_ff @(posedge clk)
    begin
        if (accept && phase_reg == PH_HEADER)
        begin
            hdr_reg <= hdr_full[HDR_W-BYTE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept && push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept && push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign out_valid                = out_valid_reg;
    assign event_kind               = out_reg.event_kind;
    assign data_byte                = out_reg.data_byte;
    assign end_of_message           = out_reg.end_of_message;
    assign signed_message           = out_reg.signed_message;
    assign ack_request              = out_reg.ack_request;
    assign sequence_res             = out_reg.sequence_res;
    assign topic_length             = out_reg.topic_length;
    assign delivered_payload_length = out_reg.delivered_payload_length;

endmodule

`default_nettype wire

FILE: tb/tb_binary_message_frame_receiver_top.sv
// tb_binary_message_frame_receiver_top: self-checking testbench for the frame receiver
// depends on bmfr_pkg and binary_message_frame_receiver_top; a built-in parser model
// predicts every result, and directed and random frames run under random handshake stalls
`default_nettype none

module tb_binary_message_frame_receiver_top;
    import bmfr_pkg::*;

    localparam int MAX_TOPIC   = 256;
    localparam int MAX_PAYLOAD = 2000;
    localparam int SIG_PREFIX  = 68;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 1000000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [BYTE_W-1:0]     rx_byte;
    logic                  out_valid;
    logic                  out_ready;
    logic [KIND_W-1:0]     event_kind;
    logic [BYTE_W-1:0]     data_byte;
    logic                  end_of_message;
    logic                  signed_message;
    logic                  ack_request;
    logic [SEQ_W-1:0]      sequence_res;
    logic [TLEN_OW-1:0]    topic_length;
    logic [PLEN_OW-1:0]    delivered_payload_length;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    binary_message_frame_receiver_top #(
        .MAX_TOPIC_BYTES        (MAX_TOPIC),
        .MAX_PAYLOAD_BYTES      (MAX_PAYLOAD),
        .SIGNATURE_PREFIX_BYTES (SIG_PREFIX)
    ) uut (
        .clk                      (clk),
        .rst_n                    (rst_n),
        .in_valid                 (in_valid),
        .in_ready                 (in_ready),
        .rx_byte                  (rx_byte),
        .out_valid                (out_valid),
        .out_ready                (out_ready),
        .event_kind               (event_kind),
        .data_byte                (data_byte),
        .end_of_message           (end_of_message),
        .signed_message           (signed_message),
        .ack_request              (ack_request),
        .sequence_res             (sequence_res),
        .topic_length             (topic_length),
        .delivered_payload_length (delivered_payload_length),
        .cfg_write                (cfg_write),
        .cfg_index                (cfg_index),
        .cfg_data                 (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // parser model state, reset values
    logic              eo_reg       = 1'b0;
    logic [BYTE_W-1:0] pub_code     = PUBLISH_CODE_RST;
    logic [BYTE_W-1:0] spub_code    = SIGNED_CODE_RST;
    logic              in_body      = 1'b0;
    int unsigned       frame_pos    = 0;
    logic [BYTE_W-1:0] hdr_store [HDR_BYTES];
    logic [BYTE_W-1:0] frame_cmd    = '0;
    int unsigned       frame_tlen   = 0;
    int unsigned       frame_plen   = 0;
    logic [SEQ_W-1:0]  frame_seq    = '0;

    result_t pending_events [$];
    int      mismatches    = 0;
    int      rx_count      = 0;
    int      cycle_count   = 0;
    logic    src_idle_on   = 1'b1;
    logic    sink_idle_on  = 1'b1;
    logic    hold_request  = 1'b0;

    function automatic logic frame_is_publish();
        return frame_cmd == pub_code || frame_cmd == spub_code;
    endfunction

    function automatic logic frame_is_signed();
        return frame_cmd == spub_code;
    endfunction

    function automatic int unsigned prefix_skip();
        return (frame_is_signed() && frame_plen >= SIG_PREFIX) ? SIG_PREFIX : 0;
    endfunction

    function automatic result_t make_event(input logic [KIND_W-1:0] kind,
                                           input logic [BYTE_W-1:0] value,
                                           input logic is_last);
        result_t r;
        r.event_kind               = kind;
        r.data_byte                = value;
        r.end_of_message           = is_last;
        r.signed_message           = frame_is_signed();
        r.ack_request              = is_last && eo_reg && (frame_seq != '0);
        r.sequence_res             = frame_seq;
        r.topic_length             = TLEN_OW'(frame_tlen);
        r.delivered_payload_length = PLEN_OW'(frame_plen - prefix_skip());
        return r;
    endfunction

    function automatic result_t make_error(input logic [KIND_W-1:0] kind);
        result_t r;
        r            = '0;
        r.event_kind = kind;
        return r;
    endfunction

    task automatic queue_event(input result_t r);
        pending_events = {pending_events, r};
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_EXACTLY_ONCE:   eo_reg    = value[0];
            CFG_PUBLISH_CODE:   pub_code  = value;
            CFG_SIGNED_PUBLISH: spub_code = value;
            default: ;
        endcase
    endtask

    task automatic track_rx_byte(input logic [BYTE_W-1:0] value);
        int unsigned tlen;
        int unsigned plen;
        int unsigned p;
        logic        is_last;
        if (!in_body)
        begin
            hdr_store[4'(frame_pos)] = value;
            frame_pos++;
            if (frame_pos < HDR_BYTES)
                return;
            frame_pos = 0;
            tlen = 32'({hdr_store[2], hdr_store[3]});
            plen = {hdr_store[4], hdr_store[5], hdr_store[6], hdr_store[7]};
            if (hdr_store[0] != VERSION_ONE)
                queue_event(make_error(KIND_BAD_VER));
            else if (tlen > MAX_TOPIC || plen > MAX_PAYLOAD)
                queue_event(make_error(KIND_TOO_LARGE));
            else
            begin
                frame_cmd  = hdr_store[1];
                frame_tlen = tlen;
                frame_plen = plen;
                frame_seq  = {hdr_store[8], hdr_store[9], hdr_store[10], hdr_store[11],
                              hdr_store[12], hdr_store[13], hdr_store[14], hdr_store[15]};
                if (tlen + plen == 0)
                begin
                    if (frame_is_publish())
                        queue_event(make_event(KIND_EMPTY_END, '0, 1'b1));
                end
                else
                    in_body = 1'b1;
            end
        end
        else
        begin
            p       = frame_pos;
            is_last = (p + 1 >= frame_tlen + frame_plen);
            if (is_last)
            begin
                in_body   = 1'b0;
                frame_pos = 0;
            end
            else
                frame_pos = p + 1;
            if (frame_is_publish())
            begin
                if (p < frame_tlen)
                    queue_event(make_event(KIND_TOPIC, value, is_last));
                else if (p - frame_tlen >= prefix_skip())
                    queue_event(make_event(KIND_PAYLOAD, value, is_last));
                else if (is_last)
                    queue_event(make_event(KIND_EMPTY_END, '0, 1'b1));
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (pending_events.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual kind %0d data %0h",
                     $time, got.event_kind, got.data_byte);
            mismatches++;
            return;
        end
        want = pending_events.pop_front();
        compare_field("event_kind", 64'(want.event_kind), 64'(got.event_kind));
        compare_field("data_byte", 64'(want.data_byte), 64'(got.data_byte));
        compare_field("end_of_message", 64'(want.end_of_message),
                      64'(got.end_of_message));
        compare_field("signed_message", 64'(want.signed_message),
                      64'(got.signed_message));
        compare_field("ack_request", 64'(want.ack_request), 64'(got.ack_request));
        compare_field("sequence_res", want.sequence_res, got.sequence_res);
        compare_field("topic_length", 64'(want.topic_length), 64'(got.topic_length));
        compare_field("delivered_payload_length", 64'(want.delivered_payload_length),
                      64'(got.delivered_payload_length));
    endtask

    always @(posedge clk)
    begin : monitor
        result_t got;
        if (rst_n)
        begin
            if (cfg_write)
                apply_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
            begin
                track_rx_byte(rx_byte);
                rx_count++;
            end
            if (out_valid && out_ready)
            begin
                got.event_kind               = event_kind;
                got.data_byte                = data_byte;
                got.end_of_message           = end_of_message;
                got.signed_message           = signed_message;
                got.ack_request              = ack_request;
                got.sequence_res             = sequence_res;
                got.topic_length             = topic_length;
                got.delivered_payload_length = delivered_payload_length;
                check_result(got);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still expected", $time, pending_events.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random stalls plus an occasional long hold-off
    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // called and returns at a falling edge; valid stays up for a back-to-back transaction
    task automatic send_byte(input logic [BYTE_W-1:0] value);
        int gap;
        if (src_idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= value;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_codes(input logic eo, input logic [7:0] pub, input logic [7:0] spub);
        write_reg(CFG_EXACTLY_ONCE, {7'd0, eo});
        write_reg(CFG_PUBLISH_CODE, pub);
        write_reg(CFG_SIGNED_PUBLISH, spub);
    endtask

    task automatic send_frame(input logic [7:0] ver, input logic [7:0] cmd,
                              input logic [15:0] tlen, input logic [31:0] plen,
                              input logic [63:0] seq);
        logic [HDR_W-1:0] hdr;
        int               body;
        hdr  = {ver, cmd, tlen, plen, seq};
        for (int i = HDR_BYTES - 1; i >= 0; i--)
            send_byte(hdr[i*8 +: 8]);
        body = (ver == VERSION_ONE && tlen <= MAX_TOPIC && plen <= MAX_PAYLOAD) ?
               int'(tlen) + int'(plen) : 0;
        repeat (body) send_byte(8'($urandom_range(0, 255)));
    endtask

    // fill out whatever header or body the parser is in the middle of
    task automatic align_to_header();
        while (in_body || frame_pos != 0)
            send_byte(in_body ? 8'($urandom_range(0, 255)) : 8'h00);
    endtask

    task automatic send_random_frame(input logic [7:0] pub, input logic [7:0] spub);
        logic [7:0]  ver;
        logic [7:0]  cmd;
        logic [15:0] tlen;
        logic [31:0] plen;
        logic [63:0] seq;
        int          pick;
        pick = $urandom_range(0, 99);
        ver  = (pick < 92) ? VERSION_ONE : 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        cmd  = (pick < 40) ? pub : (pick < 70) ? spub : 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 70)
            tlen = 16'($urandom_range(0, 6));
        else if (pick < 93)
            tlen = 16'($urandom_range(7, 40));
        else if (pick < 96)
            tlen = 16'($urandom_range(MAX_TOPIC, MAX_TOPIC + 1));
        else
            tlen = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 50)
            plen = $urandom_range(0, 10);
        else if (pick < 75)
            plen = $urandom_range(SIG_PREFIX - 8, SIG_PREFIX + 7);
        else if (pick < 92)
            plen = $urandom_range(11, 40);
        else if (pick < 97)
            plen = $urandom_range(MAX_PAYLOAD + 1, MAX_PAYLOAD + 3);
        else
            plen = $urandom;
        seq = ($urandom_range(0, 99) < 30) ? '0 : {$urandom, $urandom};
        send_frame(ver, cmd, tlen, plen, seq);
    endtask

    task automatic test_small_publish();
        send_frame(VERSION_ONE, PUBLISH_CODE_RST, 16'd0, 32'd0, 64'd0);
        send_frame(VERSION_ONE, PUBLISH_CODE_RST, 16'd1, 32'd1, 64'h0123_4567_89ab_cdef);
        send_frame(VERSION_ONE, PUBLISH_CODE_RST, 16'd0, 32'd2, 64'd7);
        drain();
    endtask

    task automatic test_header_errors();
        send_frame(8'h00, PUBLISH_CODE_RST, 16'd1, 32'd1, 64'd1);
        send_frame(8'hff, PUBLISH_CODE_RST, 16'd0, 32'd0, 64'd0);
        send_frame(VERSION_ONE, PUBLISH_CODE_RST, 16'd257, 32'd0, 64'd2);
        send_frame(VERSION_ONE, PUBLISH_CODE_RST, 16'hffff, 32'd0, 64'd3);
        send_frame(VERSION_ONE, PUBLISH_CODE_RST, 16'd0, 32'd2001, 64'd4);
        send_frame(VERSION_ONE, SIGNED_CODE_RST, 16'd0, 32'hffff_ffff, '1);
        // version is checked ahead of the lengths
        send_frame(8'h02, PUBLISH_CODE_RST, 16'd300, 32'd5000, 64'd5);
        drain();
    endtask

    task automatic test_signature_skip();
        send_frame(VERSION_ONE, SIGNED_CODE_RST, 16'd0, 32'd68, 64'd9);
        send_frame(VERSION_ONE, SIGNED_CODE_RST, 16'd2, 32'd69, 64'd10);
        send_frame(VERSION_ONE, SIGNED_CODE_RST, 16'd1, 32'd67, 64'd11);
        send_frame(VERSION_ONE, SIGNED_CODE_RST, 16'd3, 32'd68, 64'd12);
        send_frame(VERSION_ONE, SIGNED_CODE_RST, 16'd0, 32'd0, 64'd13);
        drain();
    endtask

    task automatic test_silent_commands();
        send_frame(VERSION_ONE, 8'h02, 16'd0, 32'd0, 64'd1);
        send_frame(VERSION_ONE, 8'h30, 16'd3, 32'd4, 64'd2);
        send_frame(VERSION_ONE, PUBLISH_CODE_RST, 16'd1, 32'd0, 64'd3);
        drain();
    endtask

    task automatic test_ack_request();
        set_codes(1'b1, PUBLISH_CODE_RST, SIGNED_CODE_RST);
        send_frame(VERSION_ONE, PUBLISH_CODE_RST, 16'd0, 32'd1, 64'd0);
        send_frame(VERSION_ONE, PUBLISH_CODE_RST, 16'd0, 32'd0, '1);
        send_frame(VERSION_ONE, SIGNED_CODE_RST, 16'd0, 32'd68, 64'd5);
        send_frame(VERSION_ONE, PUBLISH_CODE_RST, 16'd2, 32'd1, 64'h8000_0000_0000_0000);
        set_codes(1'b0, PUBLISH_CODE_RST, SIGNED_CODE_RST);
    endtask

    task automatic test_code_extremes();
        set_codes(1'b1, 8'h00, 8'hff);
        send_frame(VERSION_ONE, 8'h00, 16'd1, 32'd1, 64'd1);
        send_frame(VERSION_ONE, 8'hff, 16'd1, 32'd70, 64'd2);
        send_frame(VERSION_ONE, PUBLISH_CODE_RST, 16'd1, 32'd1, 64'd3);
        set_codes(1'b0, 8'hff, 8'h00);
        send_frame(VERSION_ONE, 8'hff, 16'd0, 32'd2, 64'd4);
        send_frame(VERSION_ONE, 8'h00, 16'd0, 32'd68, 64'd5);
    endtask

    // one code for both kinds: the frame counts as signed
    task automatic test_equal_codes();
        set_codes(1'b1, 8'h5a, 8'h5a);
        send_frame(VERSION_ONE, 8'h5a, 16'd1, 32'd70, 64'd6);
        send_frame(VERSION_ONE, 8'h5a, 16'd2, 32'd3, 64'd0);
        set_codes(1'b0, PUBLISH_CODE_RST, SIGNED_CODE_RST);
    endtask

    task automatic test_length_limits();
        send_frame(VERSION_ONE, PUBLISH_CODE_RST, 16'd256, 32'd0, 64'd20);
        drain();
    endtask

    task automatic test_backpressure();
        src_idle_on  = 1'b0;
        hold_request = 1'b1;
        send_frame(VERSION_ONE, PUBLISH_CODE_RST, 16'd24, 32'd40, 64'd30);
        drain();
        src_idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [7:0] pub;
        logic [7:0] spub;
        logic       eo;
        int         stop_at;
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       begin eo = 1'b0; pub = PUBLISH_CODE_RST; spub = SIGNED_CODE_RST; end
                1:       begin eo = 1'b1; pub = 8'h00; spub = 8'hff; end
                2:       begin eo = 1'b1; pub = 8'hff; spub = 8'h00; end
                3:       begin eo = 1'b0; pub = 8'h33; spub = 8'h33; end
                default:
                begin
                    eo   = 1'($urandom_range(0, 1));
                    pub  = 8'($urandom_range(0, 255));
                    spub = 8'($urandom_range(0, 255));
                end
            endcase
            align_to_header();
            set_codes(eo, pub, spub);
            src_idle_on  = (ph != 3);
            sink_idle_on = (ph != 3);
            stop_at = rx_count + 20;
            while (rx_count < stop_at)
            begin
                if ($urandom_range(0, 99) < 8)
                begin
                    repeat ($urandom_range(1, 20)) send_byte(8'($urandom_range(0, 255)));
                    align_to_header();
                end
                else
                    send_random_frame(pub, spub);
            end
        end
        align_to_header();
    endtask

    task automatic test_final_burst();
        int stop_at;
        set_codes(1'b1, PUBLISH_CODE_RST, SIGNED_CODE_RST);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        stop_at = rx_count + 50;
        while (rx_count < stop_at)
            send_random_frame(PUBLISH_CODE_RST, SIGNED_CODE_RST);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_small_publish();
        test_header_errors();
        test_signature_skip();
        test_silent_commands();
        test_ack_request();
        test_code_extremes();
        test_equal_codes();
        test_length_limits();
        test_backpressure();
        test_random_traffic();
        test_final_burst();

        drain();
        repeat (10) @(negedge clk);
        if (pending_events.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_events.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/bmfr_pkg.sv
rtl/core/binary_message_frame_receiver_top.sv
tb/tb_binary_message_frame_receiver_top.sv
